// ----- sv/pfd_pkg.sv -----
// Shared types and constants of the position frame deframer.
// Used by pfd_cell, pfd_matcher and position_frame_deframer; no dependencies.
`default_nettype none

package pfd_pkg;

  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 32;
  localparam int NUM_WORDS     = 6;
  localparam int PAYLOAD_BYTES = 24;
  localparam int CHECK_BYTES   = 2;
  localparam int CNT_W         = 5;
  localparam int OUT_W         = NUM_WORDS * WORD_W;

  localparam logic [BYTE_W-1:0] FRAME_ID_BYTE  = 8'h01;
  localparam logic [BYTE_W-1:0] FRAME_LEN_BYTE = 8'h18;

  localparam logic [CNT_W-1:0] PAYLOAD_LAST = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [CNT_W-1:0] CHECK_LAST   = CNT_W'(CHECK_BYTES - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEAD_FIRST  = 2'd0,
    CFG_HEAD_SECOND = 2'd1,
    CFG_TAIL_FIRST  = 2'd2,
    CFG_TAIL_SECOND = 2'd3
  } cfg_idx_t;

  // Frame matcher phases
  typedef enum logic [7:0] {
    PH_HEAD0   = 8'b0000_0001,
    PH_HEAD1   = 8'b0000_0010,
    PH_ID      = 8'b0000_0100,
    PH_LEN     = 8'b0000_1000,
    PH_PAYLOAD = 8'b0001_0000,
    PH_CHECK   = 8'b0010_0000,
    PH_TAIL0   = 8'b0100_0000,
    PH_TAIL1   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head_first;
    logic [BYTE_W-1:0] head_second;
    logic [BYTE_W-1:0] tail_first;
    logic [BYTE_W-1:0] tail_second;
  } match_cfg_t;

  typedef struct packed {
    logic shift_en;
    logic emit;
  } match_ctl_t;

endpackage

`default_nettype wire

// ----- sv/pfd_cell.sv -----
// One byte cell of the payload shift chain.
// Depends on pfd_pkg.
`default_nettype none

module pfd_cell
  import pfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [BYTE_W-1:0] d_in,
  output logic      [BYTE_W-1:0] q
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  // advance on shift, hold otherwise
  assign byte_nxt = shift_en ? d_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;

endmodule

`default_nettype wire

// ----- sv/pfd_matcher.sv -----
// Eight-phase frame matcher: header, id, length, payload, check, tail.
// Depends on pfd_pkg.
`default_nettype none

module pfd_matcher
  import pfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_acc,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire match_cfg_t        cfg,
  output match_ctl_t             ctl,
  output logic                   tail_wait
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next accepted byte is the second tail byte and may emit a result
  assign tail_wait = (phase_r == PH_TAIL1);

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    ctl.shift_en = 1'b0;
    ctl.emit     = 1'b0;
    if (byte_acc) begin
      case (phase_r)
        PH_HEAD0: begin
          phase_nxt = (rx_byte == cfg.head_first) ? PH_HEAD1 : PH_HEAD0;
        end
        PH_HEAD1: begin
          phase_nxt = (rx_byte == cfg.head_second) ? PH_ID : PH_HEAD0;
        end
        PH_ID: begin
          phase_nxt = (rx_byte == FRAME_ID_BYTE) ? PH_LEN : PH_HEAD0;
        end
        PH_LEN: begin
          phase_nxt = (rx_byte == FRAME_LEN_BYTE) ? PH_PAYLOAD : PH_HEAD0;
          cnt_nxt   = '0;
        end
        PH_PAYLOAD: begin
          ctl.shift_en = 1'b1;
          if (cnt_r == PAYLOAD_LAST) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CHECK;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        PH_CHECK: begin
          // skip check bytes unverified
          if (cnt_r == CHECK_LAST) begin
            cnt_nxt   = '0;
            phase_nxt = PH_TAIL0;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        PH_TAIL0: begin
          phase_nxt = (rx_byte == cfg.tail_first) ? PH_TAIL1 : PH_HEAD0;
        end
        PH_TAIL1: begin
          cnt_nxt   = '0;
          phase_nxt = PH_HEAD0;
          ctl.emit  = (rx_byte == cfg.tail_second);
        end
        default: begin
          phase_nxt = PH_HEAD0;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PAYLOAD_LAST)
    else $error("byte counter beyond payload length");

  a_payload_done: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && phase_r == PH_PAYLOAD && cnt_r == PAYLOAD_LAST) |=> phase_r == PH_CHECK)
    else $error("payload end did not move to check bytes");

  a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> (phase_r == PH_HEAD0 && cnt_r == '0))
    else $error("matcher did not restart after a frame");

endmodule

`default_nettype wire

// ----- sv/position_frame_deframer.sv -----
// Top level of the position frame deframer: config registers, cell chain, output register.
// Depends on pfd_pkg, pfd_cell and pfd_matcher.
`default_nettype none

// Position frame deframer. Feed one received serial byte per request on in_*;
// the block matches frames of the form header byte 0, header byte 1, id 0x01,
// length 0x18, 24 payload bytes, 2 check bytes (skipped, not verified), tail
// byte 0, tail byte 1. A byte that fails a match drops the frame and is consumed
// without being tried as a new header. On a matching second tail byte one result
// request carries the six little-endian 32-bit payload words. The matcher
// acts on each accepted byte and payload bytes enter a chain of 24 byte
// cells that shifts one place per payload byte, so a byte is taken every cycle
// while in_tready is high. A finished result is held in an output register and
// appears in the cycle after its last byte is accepted. Input bytes keep flowing
// while it waits; only when the matcher expects a second tail byte, which could
// bring a new result, does in_tready drop until out_tready takes the old one.
// Header and tail values must be written through cfg_* only while the block is
// idle, which the block itself does not enforce; all four reset to zero.

module position_frame_deframer
  import pfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  // received bytes
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,   // [7:0] rx_byte
  // decoded frames
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [31:0] pos_x_bits, [63:32] pos_y_bits, [95:64] yaw_angle_bits,
  // [127:96] yaw_rate_bits, [159:128] speed_y_bits, [191:160] spare_word_bits
  output logic      [OUT_W-1:0]  out_tdata
);

  match_cfg_t cfg_r, cfg_nxt;
  match_ctl_t ctl;
  logic       byte_acc;
  logic       tail_wait;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [BYTE_W-1:0] cell_q [PAYLOAD_BYTES];
  logic [OUT_W-1:0]  payload_flat;

  // Config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEAD_FIRST:  cfg_nxt.head_first  = cfg_wdata;
        CFG_HEAD_SECOND: cfg_nxt.head_second = cfg_wdata;
        CFG_TAIL_FIRST:  cfg_nxt.tail_first  = cfg_wdata;
        CFG_TAIL_SECOND: cfg_nxt.tail_second = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold the second tail byte while a held result is still waiting to be taken
  assign in_tready = !(out_valid_r && !out_tready && tail_wait);
  assign byte_acc  = in_tvalid && in_tready;

  pfd_matcher u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_tdata),
    .cfg       (cfg_r),
    .ctl       (ctl),
    .tail_wait (tail_wait)
  );

  // Cell chain: new byte enters the top cell, older bytes move down one place.
  // After 24 payload bytes cell j holds payload byte j.
  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
    logic [BYTE_W-1:0] d_in;
    if (i == PAYLOAD_BYTES - 1) begin : g_top
      assign d_in = in_tdata;
    end else begin : g_mid
      assign d_in = cell_q[i+1];
    end
    pfd_cell u_cell (
      .clk      (clk),
      .shift_en (ctl.shift_en),
      .d_in     (d_in),
      .q        (cell_q[i])
    );
    assign payload_flat[i*BYTE_W +: BYTE_W] = cell_q[i];
  end

  // Output register: load on emit, drop valid once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = payload_flat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.emit))
    else $error("result appeared without a matched frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !ctl.emit)
    else $error("pending result overwritten");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> (out_valid_r && out_data_r == $past(payload_flat)))
    else $error("emitted frame not loaded into output register");

endmodule

`default_nettype wire
